// File: rtl/fqs_pkg.sv
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared codes and the command/status bundles that connect the queue
// controller to its datapath.
// ----------------------------------------------------------------------------
package fqs_pkg;

    localparam int MODE_W    = 3;
    localparam int KIND_W    = 3;
    localparam int DATA_W    = 32;

    // operation codes of an input item
    typedef enum logic [MODE_W-1:0] {
        MODE_DEQ     = 3'd0,
        MODE_ENQ     = 3'd1,
        MODE_SIZE    = 3'd2,
        MODE_SEARCH  = 3'd3,
        MODE_DISPLAY = 3'd4
    } mode_t;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SIZE      = 3'd0,
        KIND_FOUND     = 3'd1,
        KIND_NOT_FOUND = 3'd2,
        KIND_ELEMENT   = 3'd3,
        KIND_EMPTY     = 3'd4,
        KIND_DROPPED   = 3'd5
    } kind_t;

    // payload source of a single-item result
    typedef enum logic [1:0] {
        PSEL_VALUE = 2'd0,
        PSEL_KEY   = 2'd1,
        PSEL_OCC   = 2'd2,
        PSEL_ZERO  = 2'd3
    } psel_t;

    typedef struct packed {
        logic  take;       // capture the input value as search key
        logic  enq;        // write entry at back, advance back
        logic  deq;        // advance front
        logic  rd_start;   // read entry at front, clear walk count
        logic  rd_next;    // read next entry, bump walk count
        logic  res_set;    // stage a single-item result
        kind_t res_kind;
        psel_t res_psel;
        logic  out_res;    // move staged result into output register
        logic  out_elem;   // move read entry into output register
    } cmd_t;

    typedef struct packed {
        logic occ_zero;
        logic full;
        logic hit;         // entry just read equals key
        logic walk_last;   // entry just read is the newest one
        logic out_free;    // output register can take an item
    } sts_t;

endpackage

// File: rtl/fqs_datapath.sv
// ----------------------------------------------------------------------------
// fqs_datapath
// Ring store, pointers, occupancy, walk counter and output register.
// ----------------------------------------------------------------------------
module fqs_datapath import fqs_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic signed [DATA_W-1:0] s_value,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [KIND_W-1:0]        m_kind,
    output logic signed [DATA_W-1:0] m_payload,
    output logic                     m_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [AW-1:0]            front_reg, front_next;
    logic [AW-1:0]            back_reg,  back_next;
    logic [CW-1:0]            occ_reg,   occ_next;
    logic [AW-1:0]            pos_reg,   pos_next;
    logic [CW-1:0]            cnt_reg,   cnt_next;
    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [AW-1:0]            rd_addr;
    logic                     rd_en;
    kind_t                    res_kind_reg;
    logic signed [DATA_W-1:0] res_payload_reg, res_payload_next;
    logic                     m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]        m_kind_reg;
    logic signed [DATA_W-1:0] m_payload_reg;
    logic                     m_last_reg;
    logic                     out_free;

    // pointer and occupancy update
    always_comb begin
        front_next = front_reg;
        back_next  = back_reg;
        occ_next   = occ_reg;
        if (cmd.enq) begin
            back_next = wrap_inc(back_reg);
            occ_next  = occ_reg + CW'(1);
        end else if (cmd.deq) begin
            front_next = wrap_inc(front_reg);
            occ_next   = occ_reg - CW'(1);
        end
    end

    // walk address
    always_comb begin
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        rd_en    = cmd.rd_start | cmd.rd_next;
        rd_addr  = wrap_inc(pos_reg);
        if (cmd.rd_start) begin
            rd_addr  = front_reg;
            pos_next = front_reg;
            cnt_next = '0;
        end else if (cmd.rd_next) begin
            pos_next = wrap_inc(pos_reg);
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_comb begin
        case (cmd.res_psel)
            PSEL_VALUE: res_payload_next = s_value;
            PSEL_KEY:   res_payload_next = key_reg;
            PSEL_OCC:   res_payload_next = DATA_W'(occ_reg);
            PSEL_ZERO:  res_payload_next = '0;
            default:    res_payload_next = '0;
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_res || cmd.out_elem) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg   <= '0;
            back_reg    <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            front_reg   <= front_next;
            back_reg    <= back_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        cnt_reg <= cnt_next;
        if (cmd.take) begin
            key_reg <= s_value;
        end
        if (cmd.res_set) begin
            res_kind_reg    <= cmd.res_kind;
            res_payload_reg <= res_payload_next;
        end
        if (cmd.out_res) begin
            m_kind_reg    <= res_kind_reg;
            m_payload_reg <= res_payload_reg;
            m_last_reg    <= 1'b1;
        end else if (cmd.out_elem) begin
            m_kind_reg    <= KIND_ELEMENT;
            m_payload_reg <= rd_data_reg;
            m_last_reg    <= cnt_reg + CW'(1) == occ_reg;
        end
    end

    // ring store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.enq) begin
            mem[back_reg] <= s_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign sts.occ_zero  = occ_reg == '0;
    assign sts.full      = occ_reg == CW'(DEPTH);
    assign sts.hit       = rd_data_reg == key_reg;
    assign sts.walk_last = cnt_reg + CW'(1) == occ_reg;
    assign sts.out_free  = out_free;

    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_payload = m_payload_reg;
    assign m_last    = m_last_reg;

endmodule

// File: rtl/fqs_ctrl.sv
// ----------------------------------------------------------------------------
// fqs_ctrl
// Queue controller: decodes the operation and sequences search and display
// walks over the ring store.
// ----------------------------------------------------------------------------
module fqs_ctrl import fqs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [MODE_W-1:0] s_mode,
    input  sts_t              sts,
    output cmd_t              cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SRCH = 4'b0010,
        ST_DISP = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = state_reg == ST_IDLE;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        cmd.take     = accept;
        cmd.enq      = 1'b0;
        cmd.deq      = 1'b0;
        cmd.rd_start = 1'b0;
        cmd.rd_next  = 1'b0;
        cmd.res_set  = 1'b0;
        cmd.res_kind = KIND_SIZE;
        cmd.res_psel = PSEL_VALUE;
        cmd.out_res  = 1'b0;
        cmd.out_elem = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (mode_t'(s_mode))
                        MODE_DEQ: begin
                            cmd.deq = !sts.occ_zero;
                        end
                        MODE_ENQ: begin
                            if (sts.full) begin
                                cmd.res_set  = 1'b1;
                                cmd.res_kind = KIND_DROPPED;
                                cmd.res_psel = PSEL_VALUE;
                                state_next   = ST_RESP;
                            end else begin
                                cmd.enq = 1'b1;
                            end
                        end
                        MODE_SIZE: begin
                            cmd.res_set  = 1'b1;
                            cmd.res_kind = KIND_SIZE;
                            cmd.res_psel = PSEL_OCC;
                            state_next   = ST_RESP;
                        end
                        MODE_SEARCH: begin
                            if (sts.occ_zero) begin
                                cmd.res_set  = 1'b1;
                                cmd.res_kind = KIND_NOT_FOUND;
                                cmd.res_psel = PSEL_VALUE;
                                state_next   = ST_RESP;
                            end else begin
                                cmd.rd_start = 1'b1;
                                state_next   = ST_SRCH;
                            end
                        end
                        MODE_DISPLAY: begin
                            if (sts.occ_zero) begin
                                cmd.res_set  = 1'b1;
                                cmd.res_kind = KIND_EMPTY;
                                cmd.res_psel = PSEL_ZERO;
                                state_next   = ST_RESP;
                            end else begin
                                cmd.rd_start = 1'b1;
                                state_next   = ST_DISP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SRCH: begin
                if (sts.hit) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = KIND_FOUND;
                    cmd.res_psel = PSEL_KEY;
                    state_next   = ST_RESP;
                end else if (sts.walk_last) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = KIND_NOT_FOUND;
                    cmd.res_psel = PSEL_KEY;
                    state_next   = ST_RESP;
                end else begin
                    cmd.rd_next = 1'b1;
                end
            end
            ST_DISP: begin
                if (sts.out_free) begin
                    cmd.out_elem = 1'b1;
                    if (sts.walk_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.out_res = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/fifo_queue_with_search_unit.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_search_unit
// First-in first-out queue of signed 32-bit values with size, search and
// display operations, built as a controller plus a ring-store datapath.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_mode[2:0], s_value[31:0]
//  m_        out        m_valid / m_ready    m_kind[2:0], m_payload[31:0], m_last
//
//  dequeue, enqueue with room and unused codes produce no m_ item and keep s_ready high
//  size, dropped enqueue and the empty answers pass through the staged result register to m_
//  search stops at the first match or at the newest entry, display sends every entry:
//  both walk the ring store through its single registered read port,
//  one entry per cycle, a display walk only while the m_ register can take an item
//  aresetn (synchronous, active low) empties the queue; store contents persist
//  an m_ stall holds display walks and pending answers; s_ready is low while
//  one item is in work, but not while a finished item waits in the output
//
module fifo_queue_with_search_unit import fqs_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [MODE_W-1:0]        s_mode,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [KIND_W-1:0]        m_kind,
    output logic signed [DATA_W-1:0] m_payload,
    output logic                     m_last
);

    // command and status between controller and datapath
    cmd_t cmd;
    sts_t sts;

    // controller: operation decode and walk sequencing
    fqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: ring store, pointers, occupancy, output register
    fqs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_value   (s_value),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_payload (m_payload),
        .m_last    (m_last)
    );

`ifndef ASSERT_OFF
    // a dequeue never blocks the next item
    a_deq_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_mode == MODE_DEQ) |=> s_ready)
        else $error("dequeue held off the input channel");

    // occupancy can never be both zero and full
    a_occ_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sts.occ_zero && sts.full))
        else $error("occupancy flags conflict");

    // a reported size never exceeds the store depth
    a_size_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_SIZE) |-> (m_payload <= DEPTH && m_payload >= 0))
        else $error("size result out of range");

    // the output register is loaded only when it is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_res || cmd.out_elem) |-> (!m_valid || m_ready))
        else $error("output item overwritten");
`endif

endmodule
